/* design/mur2_pkg.sv */
// ----------------------------------------------------------------------------
// mur2_pkg
// Shared constants and controller-to-datapath command type for the
// 32-bit MurmurHash2 core.
// ----------------------------------------------------------------------------
`default_nettype none

package mur2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  // datapath operations
  localparam logic [2:0] OP_NOP  = 3'd0;  // hold
  localparam logic [2:0] OP_LOAD = 3'd1;  // capture input word (and seed hash)
  localparam logic [2:0] OP_K1   = 3'd2;  // k = k * M
  localparam logic [2:0] OP_K2   = 3'd3;  // k = (k ^ k >> 24) * M
  localparam logic [2:0] OP_HMIX = 3'd4;  // h = h * M ^ k
  localparam logic [2:0] OP_TAIL = 3'd5;  // h = (h ^ tail) * M
  localparam logic [2:0] OP_FIN  = 3'd6;  // h = (h ^ h >> 13) * M
  localparam logic [2:0] OP_EMIT = 3'd7;  // out = h ^ h >> 15

  typedef struct packed {
    logic [2:0] op;
    logic       use_seed;  // with OP_LOAD: start a new message
  } cmd_t;

endpackage

`default_nettype wire

/* design/mur2_ctrl.sv */
// ----------------------------------------------------------------------------
// mur2_ctrl
// Sequencer: runs the handshakes, tracks the open message and steps the
// datapath through mix, tail and finalizer operations.
// ----------------------------------------------------------------------------
`default_nettype none

module mur2_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_byte_count,
  input  wire logic          in_first_item,
  input  wire logic          in_last_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mur2_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K1   = 3'd1;
  localparam logic [2:0] S_K2   = 3'd2;
  localparam logic [2:0] S_HMIX = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       in_msg_r, in_msg_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    in_msg_nxt    = in_msg_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = mur2_pkg::OP_NOP;
    cmd.use_seed  = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // a word with no open message and no first flag is dropped
        if (accept && (in_first_item || in_msg_r)) begin
          cmd.op       = mur2_pkg::OP_LOAD;
          cmd.use_seed = in_first_item;
          in_msg_nxt   = 1'b1;
          last_nxt     = in_last_item;
          if (!in_last_item || in_byte_count[2]) begin
            state_nxt = S_K1;
          end else if (in_byte_count[1:0] != 2'd0) begin
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_K1: begin
        cmd.op    = mur2_pkg::OP_K1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.op    = mur2_pkg::OP_K2;
        state_nxt = S_HMIX;
      end
      S_HMIX: begin
        cmd.op    = mur2_pkg::OP_HMIX;
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_TAIL: begin
        cmd.op    = mur2_pkg::OP_TAIL;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op    = mur2_pkg::OP_FIN;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.op        = mur2_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          in_msg_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_msg_r    <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_k1_to_k2: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_K1 |=> state_r == S_K2)
    else $error("K1 step not followed by K2");

  a_emit_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> in_msg_r)
    else $error("emit without an open message");

  a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAIL || state_r == S_FIN |-> last_r)
    else $error("tail or finalizer on a word that is not last");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result raised outside emit step");

endmodule

`default_nettype wire

/* design/mur2_dp.sv */
// ----------------------------------------------------------------------------
// mur2_dp
// Datapath: seed register, running hash, key register and one shared
// 32x32 multiplier (low product) by the mix constant, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mur2_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [31:0]    cfg_hash_seed,
  input  wire logic [31:0]    in_data_word,
  input  wire logic [1:0]     in_byte_count,
  input  wire logic [30:0]    in_message_length,
  input  wire mur2_pkg::cmd_t cmd,
  output logic [31:0]         out_hash_value
);

  logic [31:0] seed_r;
  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] out_r, out_nxt;
  logic [31:0] tail_mask;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_comb begin
    case (cnt_r)
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      2'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.op)
      mur2_pkg::OP_K1:   mul_a = k_r;
      mur2_pkg::OP_K2:   mul_a = k_r ^ (k_r >> mur2_pkg::MIX_SHIFT);
      mur2_pkg::OP_TAIL: mul_a = h_r ^ (k_r & tail_mask);
      mur2_pkg::OP_FIN:  mul_a = h_r ^ (h_r >> mur2_pkg::FIN_SHIFT_A);
      default:           mul_a = h_r;
    endcase
  end

  assign prod = mul_a * mur2_pkg::MIX_MUL;

  always_comb begin
    h_nxt   = h_r;
    k_nxt   = k_r;
    cnt_nxt = cnt_r;
    out_nxt = out_r;
    unique case (cmd.op)
      mur2_pkg::OP_LOAD: begin
        k_nxt   = in_data_word;
        cnt_nxt = in_byte_count;
        if (cmd.use_seed) begin
          h_nxt = seed_r ^ {1'b0, in_message_length};
        end
      end
      mur2_pkg::OP_K1,
      mur2_pkg::OP_K2:   k_nxt = prod;
      mur2_pkg::OP_HMIX: h_nxt = prod ^ k_r;
      mur2_pkg::OP_TAIL,
      mur2_pkg::OP_FIN:  h_nxt = prod;
      mur2_pkg::OP_EMIT: out_nxt = h_r ^ (h_r >> mur2_pkg::FIN_SHIFT_B);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_hash_seed;
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  assign out_hash_value = out_r;

endmodule

`default_nettype wire

/* design/murmur2_hash32_core.sv */
// ----------------------------------------------------------------------------
// murmur2_hash32_core
// Streaming 32-bit MurmurHash2 over little-endian message words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one message word per handshake,
//   first byte in bits 7:0. The first word carries the total byte length,
//   which starts the hash as seed ^ length. The last word may hold 1 to 3
//   tail bytes; an empty message is a single first+last word with count 0.
//   Words arriving with no message open and no first flag are dropped.
//   cfg_wr_en/cfg_hash_seed load the seed; write only while idle.
//   Output channel (out_valid/out_ready) gives one hash per message.
// Timing:
//   One shared multiplier does every product, one per cycle. A full word
//   occupies the core for its accept step and three multiplies. A tail word
//   takes its accept step and the tail multiply; the finalize and emit steps
//   then follow the last word's mixing, and emit waits while a result stalls.
// Reset / stall:
//   rst_n (sync, active low) clears the seed, closes any open message and
//   drops a pending result. A stalled result sits in the output register;
//   the next message's words keep being taken, and only its own emit step
//   waits for the register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur2_hash32_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_hash_seed,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_first_item,
  input  wire logic        in_last_item,
  input  wire logic [30:0] in_message_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_hash_value
);

  mur2_pkg::cmd_t cmd;

  mur2_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_count (in_byte_count),
    .in_first_item (in_first_item),
    .in_last_item  (in_last_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd)
  );

  mur2_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_hash_seed     (cfg_hash_seed),
    .in_data_word      (in_data_word),
    .in_byte_count     (in_byte_count[1:0]),
    .in_message_length (in_message_length),
    .cmd               (cmd),
    .out_hash_value    (out_hash_value)
  );

endmodule

`default_nettype wire
